>>> sv/pts_pkg.sv
// shared types, codes and helpers for the priority task scheduler
package pts_pkg;

    localparam int TASKS_DEF  = 7;
    localparam int LEVELS_DEF = 8;

    localparam int MODE_W     = 2;
    localparam int REQ_W      = 3;
    localparam int NST_W      = 2;
    localparam int CUR_W      = 3;
    localparam int PRIO_W     = 21;
    localparam int PRIO_BITS  = 3;
    localparam int PRIO_SLOTS = PRIO_W / PRIO_BITS;
    localparam int APB_DW     = 32;
    localparam int APB_AW     = 3;

    localparam logic [MODE_W-1:0] MODE_SCHEDULE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BLOCK    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_UNBLOCK  = 2'd2;

    localparam logic [NST_W-1:0] TS_READY   = 2'd0;
    localparam logic [NST_W-1:0] TS_RUNNING = 2'd1;
    localparam logic [NST_W-1:0] TS_BLOCKED = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load_req;
        logic exec;
        logic scan_step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic is_schedule;
        logic scan_done;
    } t_dp_status;

    // raw priority field of a slot, slots without a field run at level 0
    function automatic logic [PRIO_BITS-1:0] prio_of(input logic [PRIO_W-1:0] prio,
                                                     input int slot);
        logic [PRIO_BITS-1:0] p;
        p = '0;
        for (int k = 1; k <= PRIO_SLOTS; k++) begin
            if (k == slot) begin
                p = prio[PRIO_BITS*(k-1) +: PRIO_BITS];
            end
        end
        return p;
    endfunction

endpackage

>>> sv/priority_task_scheduler.sv
// Fixed-priority task scheduler: each request is a schedule tick, a block or an unblock of
// a slot, and gives one result with the current slot and two flags. A schedule tick also
// runs the level scan, which examines one priority level per clock; block, unblock and an
// unused mode skip it. A new request is taken in the cycle after the previous result is
// loaded into the output register, which may still be waiting on the consumer. Task
// priorities are written at APB addresses 0 to 3 (read back there too); the user must write
// configuration only while no request is in flight, as the block itself does not enforce it.
module priority_task_scheduler #(
    parameter int TASKS  = pts_pkg::TASKS_DEF,
    parameter int LEVELS = pts_pkg::LEVELS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [pts_pkg::MODE_W-1:0]  i_mode,
    input  logic [pts_pkg::REQ_W-1:0]   i_task_req,
    input  logic [pts_pkg::NST_W-1:0]   i_new_state,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [pts_pkg::CUR_W-1:0]   o_current_task,
    output logic                        o_unblock_found,
    output logic                        o_round_restarted,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pts_pkg::APB_AW-1:0]  paddr,
    input  logic [pts_pkg::APB_DW-1:0]  pwdata,
    output logic [pts_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import pts_pkg::*;

    logic [PRIO_W-1:0] r_task_priorities;
    logic              cfg_wr;
    logic              cfg_hit;
    t_dp_cmd           dp_cmd;
    t_dp_status        dp_status;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[APB_AW-1] == 1'b0);
    assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
    assign prdata  = cfg_hit ? {{(APB_DW-PRIO_W){1'b0}}, r_task_priorities} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_task_priorities <= '0;
        end else if (cfg_wr) begin
            r_task_priorities <= pwdata[PRIO_W-1:0];
        end
    end

    pts_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (dp_cmd),
        .i_status    (dp_status)
    );

    pts_datapath #(
        .TASKS  (TASKS),
        .LEVELS (LEVELS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (dp_cmd),
        .o_status          (dp_status),
        .i_priorities      (r_task_priorities),
        .i_mode            (i_mode),
        .i_task_req        (i_task_req),
        .i_new_state       (i_new_state),
        .o_current_task    (o_current_task),
        .o_unblock_found   (o_unblock_found),
        .o_round_restarted (o_round_restarted)
    );

endmodule

>>> sv/pts_datapath.sv
// task tables, pending scan and result registers of the scheduler
module pts_datapath #(
    parameter int TASKS  = pts_pkg::TASKS_DEF,
    parameter int LEVELS = pts_pkg::LEVELS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pts_pkg::t_dp_cmd            i_cmd,
    output pts_pkg::t_dp_status         o_status,
    input  logic [pts_pkg::PRIO_W-1:0]  i_priorities,
    input  logic [pts_pkg::MODE_W-1:0]  i_mode,
    input  logic [pts_pkg::REQ_W-1:0]   i_task_req,
    input  logic [pts_pkg::NST_W-1:0]   i_new_state,
    output logic [pts_pkg::CUR_W-1:0]   o_current_task,
    output logic                        o_unblock_found,
    output logic                        o_round_restarted
);
    import pts_pkg::*;

    localparam int SW   = $clog2(TASKS + 1);
    localparam int IXW  = (SW > REQ_W) ? SW : REQ_W;
    localparam int LCW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int CMPW = (LCW > PRIO_BITS) ? LCW : PRIO_BITS;

    logic [MODE_W-1:0] r_mode;
    logic [REQ_W-1:0]  r_req;
    logic [NST_W-1:0]  r_nst;

    logic [NST_W-1:0]  r_states [1:TASKS];
    logic [NST_W-1:0]  n_states [1:TASKS];
    logic [TASKS:1]    r_blocked, n_blocked;
    logic [TASKS:1]    r_pending, n_pending;
    logic [SW-1:0]     r_cur, n_cur;
    logic [LCW-1:0]    r_lvl, n_lvl;
    logic              r_found, n_found;
    logic              r_restarted, n_restarted;

    logic [CUR_W-1:0]  r_out_task;
    logic              r_out_found;
    logic              r_out_restart;

    logic [IXW-1:0]       req_w;
    logic [IXW-1:0]       cur_w;
    logic                 req_ok;
    logic [PRIO_BITS-1:0] p3;
    logic [CMPW-1:0]      pw;
    logic                 hit;
    logic [SW-1:0]        sel;
    logic                 sel_ready;
    logic                 last_lvl;
    logic                 chosen;

    assign req_w    = IXW'(r_req);
    assign cur_w    = IXW'(r_cur);
    assign req_ok   = (req_w != '0) && (req_w <= IXW'(TASKS));
    assign last_lvl = (r_lvl == LCW'(LEVELS - 1));

    // lowest-index pending slot at the level under scan
    always_comb begin
        hit       = 1'b0;
        sel       = '0;
        sel_ready = 1'b0;
        p3        = '0;
        pw        = '0;
        for (int s = TASKS; s >= 1; s--) begin
            p3 = prio_of(i_priorities, s);
            pw = (int'(p3) >= LEVELS) ? CMPW'(LEVELS - 1) : CMPW'(p3);
            if (r_pending[s] && (pw == CMPW'(r_lvl))) begin
                hit       = 1'b1;
                sel       = SW'(s);
                sel_ready = (r_states[s] == TS_READY);
            end
        end
    end

    assign chosen = hit && sel_ready;

    assign o_status.is_schedule = (r_mode == MODE_SCHEDULE);
    assign o_status.scan_done   = chosen || last_lvl;

    always_comb begin
        n_states    = r_states;
        n_blocked   = r_blocked;
        n_pending   = r_pending;
        n_cur       = r_cur;
        n_lvl       = r_lvl;
        n_found     = r_found;
        n_restarted = r_restarted;

        if (i_cmd.exec) begin
            n_found     = 1'b0;
            n_restarted = 1'b0;
            case (r_mode)
                MODE_SCHEDULE: begin
                    for (int s = 1; s <= TASKS; s++) begin
                        if ((r_cur == SW'(s)) && (r_states[s] == TS_RUNNING)) begin
                            n_states[s] = TS_READY;
                        end
                    end
                    // nothing pending: new round over all unblocked slots
                    if (r_pending == '0) begin
                        n_restarted = 1'b1;
                        n_pending   = ~r_blocked;
                        for (int s = 1; s <= TASKS; s++) begin
                            if (!r_blocked[s]) begin
                                n_states[s] = TS_READY;
                            end
                        end
                    end
                    n_lvl = '0;
                end
                MODE_BLOCK: begin
                    for (int s = 1; s <= TASKS; s++) begin
                        if (req_ok && (req_w == IXW'(s))) begin
                            n_blocked[s] = 1'b1;
                            n_states[s]  = TS_BLOCKED;
                        end
                    end
                end
                MODE_UNBLOCK: begin
                    for (int s = 1; s <= TASKS; s++) begin
                        if (req_ok && (req_w == IXW'(s)) && r_blocked[s]) begin
                            n_blocked[s] = 1'b0;
                            n_states[s]  = r_nst;
                            n_found      = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.scan_step) begin
            for (int s = 1; s <= TASKS; s++) begin
                if (hit && (sel == SW'(s))) begin
                    n_pending[s] = 1'b0;
                    if (sel_ready) begin
                        n_states[s] = TS_RUNNING;
                    end
                end
            end
            if (chosen) begin
                n_cur = sel;
            end else if (last_lvl) begin
                n_cur = '0;
            end else begin
                n_lvl = r_lvl + LCW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= TASKS; s++) begin
                r_states[s] <= TS_READY;
            end
            r_blocked   <= '0;
            r_pending   <= '0;
            r_cur       <= '0;
            r_lvl       <= '0;
            r_found     <= 1'b0;
            r_restarted <= 1'b0;
        end else begin
            r_states    <= n_states;
            r_blocked   <= n_blocked;
            r_pending   <= n_pending;
            r_cur       <= n_cur;
            r_lvl       <= n_lvl;
            r_found     <= n_found;
            r_restarted <= n_restarted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_mode <= i_mode;
            r_req  <= i_task_req;
            r_nst  <= i_new_state;
        end
        if (i_cmd.load_out) begin
            r_out_task    <= cur_w[CUR_W-1:0];
            r_out_found   <= r_found;
            r_out_restart <= r_restarted;
        end
    end

    assign o_current_task    = r_out_task;
    assign o_unblock_found   = r_out_found;
    assign o_round_restarted = r_out_restart;

endmodule

>>> sv/pts_controller.sv
// sequencing of one event: latch, execute, level scan (schedule ticks only), hand off result
module pts_controller (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output pts_pkg::t_dp_cmd     o_cmd,
    input  pts_pkg::t_dp_status  i_status
);
    import pts_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_status.is_schedule ? ST_SCAN : ST_FINISH;
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // wait for the result register to free up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> tb/sv/tb.sv
// testbench for the priority task scheduler: directed and random requests against a predictor
`timescale 1ns / 100ps

module tb;
    import pts_pkg::*;

    localparam int TASKS  = TASKS_DEF;
    localparam int LEVELS = LEVELS_DEF;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam logic [NST_W-1:0]  TS_OTHER    = 2'd3;
    localparam logic [APB_AW-1:0] REG_TASK_PRIO = '0;

    localparam logic [PRIO_W-1:0] PRIO_ALL_TOP = 21'h1FFFFF;
    localparam logic [PRIO_W-1:0] PRIO_ALL_LOW = 21'h000000;
    // slot 7 at level 0 down to slot 1 at level 6
    localparam logic [PRIO_W-1:0] PRIO_REVERSED = 21'o0123456;

    typedef struct packed {
        logic [CUR_W-1:0] current;
        logic             found;
        logic             restarted;
    } t_sched_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [MODE_W-1:0]   i_mode;
    logic [REQ_W-1:0]    i_task_req;
    logic [NST_W-1:0]    i_new_state;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [CUR_W-1:0]    o_current_task;
    logic                o_unblock_found;
    logic                o_round_restarted;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    // scheduler state as predicted
    logic [NST_W-1:0]    slot_state [0:TASKS];
    logic [TASKS:0]      blk_mask  = '0;
    logic [TASKS:0]      pend_mask = '0;
    logic [CUR_W-1:0]    cur_slot  = '0;
    logic [PRIO_W-1:0]   slot_prio = '0;

    t_sched_result       awaited_results [$];

    bit                  quiet_gaps = 1'b0;
    int                  errors     = 0;
    int                  n_ticks    = 0;
    int                  n_blocks   = 0;
    int                  n_unblocks = 0;
    int                  n_unused   = 0;
    int                  n_found    = 0;
    int                  n_restarts = 0;
    int                  n_idle     = 0;
    int                  n_checked  = 0;
    int                  n_configs  = 0;

    priority_task_scheduler u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_mode            (i_mode),
        .i_task_req        (i_task_req),
        .i_new_state       (i_new_state),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_current_task    (o_current_task),
        .o_unblock_found   (o_unblock_found),
        .o_round_restarted (o_round_restarted),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        for (int s = 0; s <= TASKS; s++) begin
            slot_state[s] = TS_READY;
        end
    end

    function automatic int slot_level(input int s);
        int p;
        p = 0;
        if (s >= 1 && s <= PRIO_SLOTS) begin
            p = slot_prio[PRIO_BITS*(s-1) +: PRIO_BITS];
        end
        if (p >= LEVELS) begin
            p = LEVELS - 1;
        end
        return p;
    endfunction

    // advance the predicted state by one request and return its result
    function automatic t_sched_result apply_event(input logic [MODE_W-1:0] mode,
                                                  input logic [REQ_W-1:0]  slot,
                                                  input logic [NST_W-1:0]  nst);
        t_sched_result r;
        int            pick;
        bit            chosen;
        bit            in_range;
        r        = '0;
        chosen   = 1'b0;
        in_range = (slot >= 1) && (slot <= TASKS);
        if (mode == MODE_SCHEDULE) begin
            if (cur_slot != 0 && slot_state[cur_slot] == TS_RUNNING) begin
                slot_state[cur_slot] = TS_READY;
            end
            if (pend_mask == '0) begin
                r.restarted = 1'b1;
                for (int s = 1; s <= TASKS; s++) begin
                    if (!blk_mask[s]) begin
                        pend_mask[s]  = 1'b1;
                        slot_state[s] = TS_READY;
                    end
                end
            end
            for (int lvl = 0; lvl < LEVELS && !chosen; lvl++) begin
                pick = 0;
                for (int s = TASKS; s >= 1; s--) begin
                    if (pend_mask[s] && slot_level(s) == lvl) begin
                        pick = s;
                    end
                end
                if (pick != 0) begin
                    pend_mask[pick] = 1'b0;
                    if (slot_state[pick] == TS_READY) begin
                        slot_state[pick] = TS_RUNNING;
                        cur_slot         = pick[CUR_W-1:0];
                        chosen           = 1'b1;
                    end
                end
            end
            if (!chosen) begin
                cur_slot = '0;
            end
        end else if (mode == MODE_BLOCK) begin
            if (in_range) begin
                blk_mask[slot]   = 1'b1;
                slot_state[slot] = TS_BLOCKED;
            end
        end else if (mode == MODE_UNBLOCK) begin
            if (in_range && blk_mask[slot]) begin
                blk_mask[slot]   = 1'b0;
                slot_state[slot] = nst;
                r.found          = 1'b1;
            end
        end
        r.current = cur_slot;
        return r;
    endfunction

    function automatic int draw_gap();
        return quiet_gaps ? 0 : $urandom_range(0, 11);
    endfunction

    task automatic issue_request(input logic [MODE_W-1:0] mode,
                                 input logic [REQ_W-1:0]  slot,
                                 input logic [NST_W-1:0]  nst);
        int            gap;
        t_sched_result r;
        gap = draw_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_mode      <= mode;
        i_task_req  <= slot;
        i_new_state <= nst;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        r = apply_event(mode, slot, nst);
        awaited_results.push_back(r);
        case (mode)
            MODE_SCHEDULE: n_ticks++;
            MODE_BLOCK:    n_blocks++;
            MODE_UNBLOCK:  n_unblocks++;
            default:       n_unused++;
        endcase
        n_found    += r.found;
        n_restarts += r.restarted;
        if (mode == MODE_SCHEDULE && r.current == 0) begin
            n_idle++;
        end
    endtask

    // stop sending and let every outstanding request come back
    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_priorities(input logic [PRIO_W-1:0] value);
        logic [APB_DW-1:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_TASK_PRIO;
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        slot_prio = value;
        n_configs++;
        // read back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== APB_DW'(value)) begin
            $display("%0t: priority readback expected %h actual %h", $time, value, rd);
            errors++;
        end
    endtask

    // result side: stall a random number of cycles before each result
    initial begin
        int stall;
        i_out_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_sched_result want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            n_checked++;
            if (awaited_results.size() == 0) begin
                $display("%0t: result with none expected, current_task actual %0d",
                         $time, o_current_task);
                errors++;
            end else begin
                want = awaited_results.pop_front();
                if (o_current_task !== want.current) begin
                    $display("%0t: current_task expected %0d actual %0d",
                             $time, want.current, o_current_task);
                    errors++;
                end
                if (o_unblock_found !== want.found) begin
                    $display("%0t: unblock_found expected %0d actual %0d",
                             $time, want.found, o_unblock_found);
                    errors++;
                end
                if (o_round_restarted !== want.restarted) begin
                    $display("%0t: round_restarted expected %0d actual %0d",
                             $time, want.restarted, o_round_restarted);
                    errors++;
                end
            end
        end
    end

    task automatic test_idle_and_ignored();
        issue_request(MODE_UNUSED, 3'd7, TS_OTHER);
        issue_request(MODE_BLOCK, 3'd0, TS_READY);
        issue_request(MODE_UNBLOCK, 3'd0, TS_OTHER);
        issue_request(MODE_SCHEDULE, 3'd5, TS_BLOCKED);
        issue_request(MODE_SCHEDULE, 3'd0, TS_READY);
    endtask

    task automatic test_blocking();
        // a pending task that gets blocked is taken by the scan but skipped
        issue_request(MODE_BLOCK, 3'd3, TS_READY);
        issue_request(MODE_BLOCK, 3'd3, TS_READY);
        issue_request(MODE_SCHEDULE, 3'd0, TS_READY);
        issue_request(MODE_UNBLOCK, 3'd3, TS_RUNNING);
        issue_request(MODE_UNBLOCK, 3'd3, TS_RUNNING);
        issue_request(MODE_BLOCK, 3'd5, TS_READY);
        issue_request(MODE_UNBLOCK, 3'd5, TS_OTHER);
        issue_request(MODE_SCHEDULE, 3'd0, TS_READY);
    endtask

    task automatic test_all_blocked();
        for (int s = 1; s <= TASKS; s++) begin
            issue_request(MODE_BLOCK, s[REQ_W-1:0], TS_READY);
        end
        issue_request(MODE_SCHEDULE, 3'd0, TS_READY);
        issue_request(MODE_UNBLOCK, 3'd6, TS_BLOCKED);
        issue_request(MODE_UNBLOCK, 3'd7, TS_READY);
        issue_request(MODE_SCHEDULE, 3'd0, TS_READY);
    endtask

    task automatic test_level_order();
        wait_all_results();
        write_priorities(PRIO_REVERSED);
        issue_request(MODE_SCHEDULE, 3'd0, TS_READY);
        issue_request(MODE_SCHEDULE, 3'd0, TS_READY);
    endtask

    task automatic test_random_traffic();
        logic [PRIO_W-1:0] prio;
        logic [MODE_W-1:0] mode;
        logic [REQ_W-1:0]  slot;
        logic [NST_W-1:0]  nst;
        int                pick;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0:       prio = PRIO_ALL_TOP;
                1:       prio = PRIO_ALL_LOW;
                default: prio = PRIO_W'($urandom());
            endcase
            wait_all_results();
            write_priorities(prio);
            for (int n = 0; n < 310; n++) begin
                if (n % 40 == 0) begin
                    quiet_gaps = ($urandom_range(0, 3) == 0);
                end
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    mode = MODE_SCHEDULE;
                end else if (pick < 66) begin
                    mode = MODE_BLOCK;
                end else if (pick < 95) begin
                    mode = MODE_UNBLOCK;
                end else begin
                    mode = MODE_UNUSED;
                end
                slot = REQ_W'($urandom_range(0, 7));
                // most unblocks target a task that is actually blocked
                if (mode == MODE_UNBLOCK && blk_mask[TASKS:1] != '0 &&
                        $urandom_range(0, 9) < 8) begin
                    do begin
                        slot = REQ_W'($urandom_range(1, TASKS));
                    end while (!blk_mask[slot]);
                end
                nst = ($urandom_range(0, 9) < 5) ? TS_READY : NST_W'($urandom_range(0, 3));
                issue_request(mode, slot, nst);
            end
        end
        quiet_gaps = 1'b0;
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_mode      <= MODE_SCHEDULE;
        i_task_req  <= '0;
        i_new_state <= TS_READY;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= REG_TASK_PRIO;
        pwdata      <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_and_ignored();
        test_blocking();
        test_all_blocked();
        test_level_order();
        test_random_traffic();
        wait_all_results();
        repeat (20) @(posedge i_clk);
        $display("covered %0d ticks, %0d blocks, %0d unblocks, %0d unused-mode requests",
                 n_ticks, n_blocks, n_unblocks, n_unused);
        $display("%0d results checked, %0d unblocks found, %0d round restarts,",
                 n_checked, n_found, n_restarts);
        $display("%0d idle picks, %0d priority writes", n_idle, n_configs);
        if (errors == 0) begin
            $display("priority_task_scheduler verification clean");
        end else begin
            $display("priority_task_scheduler verification failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("%0t: timeout with %0d results outstanding", $time, awaited_results.size());
        $display("priority_task_scheduler verification failed");
        $finish;
    end

endmodule
